// ----- rtl/core/fat_directory_entry_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FAT_DIRECTORY_ENTRY_DECODER_UNIT_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define FDD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdd assertion failed");
// Next-cycle implication, sampled on clk, off during reset
`define FDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdd assertion failed");
`else
`define FDD_ASSERT_IMPLY(lbl, ante, cons)
`define FDD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/fdd_pkg.sv -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - shared package
// Constants, entry record and result layout used by the front, queue and back.
// ----------------------------------------------------------------------------
package fdd_pkg;

	localparam logic [15:0] ENTRY_COUNT_RESET = 16'd512;
	localparam int          QUEUE_DEPTH       = 2;

	// Special byte values
	localparam logic [7:0]  END_MARK     = 8'h00;
	localparam logic [7:0]  DELETED_MARK = 8'hE5;
	localparam logic [7:0]  SPACE_CHAR   = 8'h20;
	localparam logic [7:0]  DOT_CHAR     = 8'h2E;
	localparam logic [11:0] YEAR_BASE    = 12'd1980;
	localparam logic [15:0] SEEN_MAX     = 16'hFFFF;

	// Byte positions inside a 32-byte entry
	localparam logic [4:0] POS_FIRST    = 5'd0;
	localparam logic [4:0] POS_EXT      = 5'd8;
	localparam logic [4:0] POS_ATTR     = 5'd11;
	localparam logic [4:0] POS_TIME_LO  = 5'd14;
	localparam logic [4:0] POS_TIME_HI  = 5'd15;
	localparam logic [4:0] POS_DATE_LO  = 5'd16;
	localparam logic [4:0] POS_DATE_HI  = 5'd17;
	localparam logic [4:0] POS_CLUS_LO  = 5'd26;
	localparam logic [4:0] POS_CLUS_HI  = 5'd27;
	localparam logic [4:0] POS_SIZE     = 5'd28;
	localparam logic [4:0] POS_LAST     = 5'd31;

	// Result slots walked by the back end
	localparam logic [3:0] SLOT_DOT   = 4'd8;
	localparam logic [3:0] SLOT_EXT0  = 4'd9;
	localparam logic [3:0] SLOT_EXT1  = 4'd10;
	localparam logic [3:0] SLOT_EXT2  = 4'd11;
	localparam logic [3:0] SLOT_FINAL = 4'd12;

	// One decoded entry (or an end marker) handed from front to back
	typedef struct packed {
		logic             is_end;
		logic [7:0][7:0]  name;
		logic [2:0][7:0]  ext;
		logic [4:0]       attr;
		logic [15:0]      time_w;
		logic [15:0]      date_w;
		logic [15:0]      cluster;
		logic [31:0]      size;
	} entry_rec_t;

	// Result payload, name_char in the lowest bits
	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] file_size;
		logic [15:0] start_cluster;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  attr_flags;
		logic [7:0]  name_char;
	} out_data_t;

endpackage

// ----- rtl/core/fdd_front.sv -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - front end
// Takes one directory byte per cycle while the queue has room, tracks entry
// position and area state, collects entry fields and pushes a record per visible entry or end marker.
// ----------------------------------------------------------------------------
module fdd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        entry_count,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_start,
	input  logic               queue_full,
	output logic               push_valid,
	output fdd_pkg::entry_rec_t push_rec
);
	import fdd_pkg::*;

	logic [4:0]      pos_q, pos_d;
	logic [15:0]     seen_q, seen_d;
	logic            done_q, done_d;
	logic [7:0][7:0] name_q, name_d;
	logic [2:0][7:0] ext_q, ext_d;
	logic [4:0]      attr_q, attr_d;
	logic [15:0]     time_q, time_d;
	logic [15:0]     date_q, date_d;
	logic [15:0]     clus_q, clus_d;
	logic [3:0][7:0] size_q, size_d;
	logic            fire;
	logic [4:0]      pos_c;
	logic [15:0]     seen_c;
	logic            done_c;
	logic [4:0]      ext_off;

	// Stall input only when the queue has no room
	assign in_ready = !queue_full;
	assign fire     = in_valid && in_ready;
	assign ext_off  = pos_c - POS_EXT;

	// Parse one byte
	always_comb begin
		pos_c  = in_start ? POS_FIRST : pos_q;
		seen_c = in_start ? 16'd0 : seen_q;
		done_c = in_start ? 1'b0 : done_q;
		pos_d  = pos_c;
		seen_d = seen_c;
		done_d = done_c;
		name_d = name_q;
		ext_d  = ext_q;
		attr_d = attr_q;
		time_d = time_q;
		date_d = date_q;
		clus_d = clus_q;
		size_d = size_q;
		push_valid = 1'b0;
		push_rec   = '0;
		if (!done_c) begin
			if (pos_c == POS_FIRST && seen_c >= entry_count) begin
				done_d = 1'b1;
			end else if (pos_c == POS_FIRST && in_byte == END_MARK) begin
				done_d = 1'b1;
				push_valid = 1'b1;
				push_rec.is_end = 1'b1;
			end else begin
				// Store the byte by position
				if (pos_c < POS_EXT) begin
					name_d[pos_c[2:0]] = in_byte;
				end else if (pos_c < POS_ATTR) begin
					ext_d[ext_off[1:0]] = in_byte;
				end else if (pos_c == POS_ATTR) begin
					attr_d = {in_byte[5], in_byte[4], in_byte[2:0]};
				end else if (pos_c == POS_TIME_LO) begin
					time_d[7:0] = in_byte;
				end else if (pos_c == POS_TIME_HI) begin
					time_d[15:8] = in_byte;
				end else if (pos_c == POS_DATE_LO) begin
					date_d[7:0] = in_byte;
				end else if (pos_c == POS_DATE_HI) begin
					date_d[15:8] = in_byte;
				end else if (pos_c == POS_CLUS_LO) begin
					clus_d[7:0] = in_byte;
				end else if (pos_c == POS_CLUS_HI) begin
					clus_d[15:8] = in_byte;
				end else if (pos_c >= POS_SIZE) begin
					size_d[pos_c[1:0]] = in_byte;
				end
				pos_d = pos_c + 5'd1;
				// Close the entry on its last byte
				if (pos_c == POS_LAST) begin
					if (seen_c != SEEN_MAX) begin
						seen_d = seen_c + 16'd1;
					end
					if (name_d[0] != DELETED_MARK) begin
						push_valid = 1'b1;
					end
					push_rec.name    = name_d;
					push_rec.ext     = ext_d;
					push_rec.attr    = attr_d;
					push_rec.time_w  = time_d;
					push_rec.date_w  = date_d;
					push_rec.cluster = clus_d;
					push_rec.size    = size_d;
				end
			end
		end
		push_valid = push_valid && fire;
	end

	// Control state and the attribute, time, date, cluster and size fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
			attr_q <= '0;
			time_q <= '0;
			date_q <= '0;
			clus_q <= '0;
			size_q <= '0;
		end else if (fire) begin
			pos_q  <= pos_d;
			seen_q <= seen_d;
			done_q <= done_d;
			attr_q <= attr_d;
			time_q <= time_d;
			date_q <= date_d;
			clus_q <= clus_d;
			size_q <= size_d;
		end
	end

	// Name and extension bytes
	always_ff @(posedge clk) begin
		if (fire) begin
			name_q <= name_d;
			ext_q  <= ext_d;
		end
	end

endmodule

// ----- rtl/core/fdd_queue.sv -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - record queue
// Short register FIFO of entry records between the front and the back end.
// ----------------------------------------------------------------------------
module fdd_queue #(
	parameter int DEPTH = fdd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  fdd_pkg::entry_rec_t push_rec,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output fdd_pkg::entry_rec_t head_rec
);
	import fdd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_rec_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Record storage
	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ----- rtl/core/fdd_back.sv -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - back end
// Walks the head record slot by slot (name, dot, extension, final) and loads
// the output register with one result per non-empty slot.
// ----------------------------------------------------------------------------
module fdd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  fdd_pkg::entry_rec_t head_rec,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [103:0]       m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);
	import fdd_pkg::*;

	logic [3:0] slot_q;
	logic       out_valid_q;
	out_data_t  out_data_q;
	logic       out_last_q;
	logic       out_status_q;
	logic       out_free;
	logic       step;
	logic       has_ext;
	logic       emit;
	logic [7:0] slot_char;
	out_data_t  next_data;

	assign out_free = !out_valid_q || m_tready;
	assign step     = head_valid && out_free;
	assign has_ext  = (head_rec.ext[0] != SPACE_CHAR) || (head_rec.ext[1] != SPACE_CHAR)
		|| (head_rec.ext[2] != SPACE_CHAR);

	// Pick the character of the current slot
	always_comb begin
		slot_char = '0;
		emit      = 1'b0;
		case (slot_q)
			SLOT_DOT: begin
				slot_char = DOT_CHAR;
				emit      = has_ext;
			end
			SLOT_EXT0: begin
				slot_char = head_rec.ext[0];
				emit      = has_ext && slot_char != SPACE_CHAR;
			end
			SLOT_EXT1: begin
				slot_char = head_rec.ext[1];
				emit      = has_ext && slot_char != SPACE_CHAR;
			end
			SLOT_EXT2: begin
				slot_char = head_rec.ext[2];
				emit      = has_ext && slot_char != SPACE_CHAR;
			end
			SLOT_FINAL: begin
				emit = 1'b1;
			end
			default: begin
				slot_char = head_rec.name[slot_q[2:0]];
				emit      = slot_char != SPACE_CHAR;
			end
		endcase
		if (head_rec.is_end) begin
			emit = 1'b1;
		end
	end

	// Build the result payload
	always_comb begin
		next_data = '0;
		if (!head_rec.is_end) begin
			if (slot_q == SLOT_FINAL) begin
				next_data.attr_flags    = head_rec.attr;
				next_data.day           = head_rec.date_w[4:0];
				next_data.month         = head_rec.date_w[8:5];
				next_data.year          = YEAR_BASE + {5'd0, head_rec.date_w[15:9]};
				next_data.hour          = head_rec.time_w[15:11];
				next_data.minute        = head_rec.time_w[10:5];
				next_data.second        = {head_rec.time_w[4:0], 1'b0};
				next_data.start_cluster = head_rec.cluster;
				next_data.file_size     = head_rec.size;
			end else begin
				next_data.name_char = slot_char;
			end
		end
	end

	// Drop the record after its final slot or end marker
	assign pop = step && (head_rec.is_end || slot_q == SLOT_FINAL);

	// Slot counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				slot_q <= pop ? 4'd0 : slot_q + 4'd1;
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_data_q   <= next_data;
			out_last_q   <= head_rec.is_end || slot_q == SLOT_FINAL;
			out_status_q <= head_rec.is_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

endmodule

// ----- rtl/core/fat_directory_entry_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// FAT directory entry decoder - top level
// Parses 32-byte root-directory entries from a byte stream into name
// characters and a final attribute/date/time/cluster/size result.
//
//   channel   dir   payload
//   s_axis    in    tdata = dir_byte, tuser = start_of_area
//   m_axis    out   tdata = name_char..file_size, tlast = last_of_entry,
//                   tuser = status
//   cfg       in    cfg_data = entry_count
//
// One byte is taken every cycle while the record queue has room; the front end
// is a single stage. Each visible entry drains through the slot sequencer of
// the back end, one slot per cycle while the output register is free, in fewer
// slots than the entry has bytes. Input stalls only while the record queue is
// full; output stalls hold the output register and then the queue. Reset clears
// all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "fat_directory_entry_decoder_unit_defines.svh"

module fat_directory_entry_decoder_unit #(
	parameter int QUEUE_DEPTH = fdd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] dir_byte
	input  logic         s_tuser,  // [0] start_of_area
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] name_char, [12:8] attr_flags, [17:13] day, [21:18] month,
	// [33:22] year, [38:34] hour, [44:39] minute, [50:45] second,
	// [66:51] start_cluster, [98:67] file_size, [103:99] zero
	output logic [103:0] m_tdata,
	output logic         m_tlast,  // last_of_entry
	output logic         m_tuser,  // [0] status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data  // entry_count
);
	import fdd_pkg::*;

	logic [15:0] entry_count_q;
	logic        push_valid;
	entry_rec_t  push_rec;
	logic        queue_full;
	logic        pop;
	logic        head_valid;
	entry_rec_t  head_rec;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RESET;
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	fdd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.in_start    (s_tuser),
		.queue_full  (queue_full),
		.push_valid  (push_valid),
		.push_rec    (push_rec)
	);

	fdd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	fdd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	// End marker is a bare last result
	`FDD_ASSERT_IMPLY(a_end_bare, m_tvalid && m_tuser, m_tlast && m_tdata == '0)
	// Name results never carry a space or entry fields
	`FDD_ASSERT_IMPLY(a_name_nospace, m_tvalid && !m_tlast, m_tdata[7:0] != SPACE_CHAR)
	`FDD_ASSERT_IMPLY(a_name_clean, m_tvalid && !m_tlast, m_tdata[103:8] == '0)
	// A push into a full queue would lose a record
	`FDD_ASSERT_NEXT(a_no_overflow, queue_full && !pop, !push_valid)

endmodule
